// ----- rtl/ovtk_pkg.sv -----
// ----------------------------------------------------------------------------
// ovtk_pkg
// Shared widths, register indexes and fault source codes for the overspeed,
// tilt and kill latch unit.
// ----------------------------------------------------------------------------
package ovtk_pkg;

  localparam int RATE_W  = 16;
  localparam int QUAT_W  = 16;
  localparam int LIM_W   = 15;
  localparam int DEB_W   = 16;
  localparam int STOP_W  = 2;
  localparam int SRC_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_USE_MAG   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DEB  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_COS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_DEB  = 3'd4;

  localparam logic [SRC_W-1:0] SRC_NONE   = 3'd0;
  localparam logic [SRC_W-1:0] SRC_RATE   = 3'd1;
  localparam logic [SRC_W-1:0] SRC_ESTOP  = 3'd2;
  localparam logic [SRC_W-1:0] SRC_TILT   = 3'd3;
  localparam logic [SRC_W-1:0] SRC_BUTTON = 3'd4;

  localparam logic [STOP_W-1:0] STOP_HARD = 2'd2;

endpackage

// ----- rtl/ovtk_in_if.sv -----
// ----------------------------------------------------------------------------
// ovtk_in_if
// Sample channel: gyro rates, attitude quaternion, stop, ack and button levels.
// ----------------------------------------------------------------------------
interface ovtk_in_if;
  import ovtk_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;
  logic signed [QUAT_W-1:0] att_w;
  logic signed [QUAT_W-1:0] att_x;
  logic signed [QUAT_W-1:0] att_y;
  logic signed [QUAT_W-1:0] att_z;
  logic [STOP_W-1:0]        stop_level;
  logic                     ack_level;
  logic                     button_level;

  modport source (
    output valid, rate_x, rate_y, rate_z, att_w, att_x, att_y, att_z,
           stop_level, ack_level, button_level,
    input  ready
  );

  modport sink (
    input  valid, rate_x, rate_y, rate_z, att_w, att_x, att_y, att_z,
           stop_level, ack_level, button_level,
    output ready
  );
endinterface

// ----- rtl/ovtk_out_if.sv -----
// ----------------------------------------------------------------------------
// ovtk_out_if
// Result channel: kill state, fault source, rate debounce count, overspeed flag and ack edge flag.
// ----------------------------------------------------------------------------
interface ovtk_out_if;
  import ovtk_pkg::*;

  logic              valid;
  logic              ready;
  logic              kill;
  logic [SRC_W-1:0]  fault_source;
  logic [DEB_W-1:0]  rate_count_out;
  logic              over_now;
  logic              ack_rise;

  modport source (
    output valid, kill, fault_source, rate_count_out, over_now, ack_rise,
    input  ready
  );

  modport sink (
    input  valid, kill, fault_source, rate_count_out, over_now, ack_rise,
    output ready
  );
endinterface

// ----- rtl/ovtk_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ovtk_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ovtk_cfg_if;
  import ovtk_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/overspeed_tilt_kill_latch_unit.sv -----
// ----------------------------------------------------------------------------
// overspeed_tilt_kill_latch_unit
// Debounced overspeed and tilt detection with a prioritized kill latch.
// ----------------------------------------------------------------------------
// Each accepted sample word is worked through in steps on the single shared
// 18x18 multiplier that forms all squares and the two tilt partial products.
// The input is not ready while a sample is in work; a finished result waits
// in the output register. Synchronous active-low reset clears the latch,
// both counters, the edge history and restores the register defaults.
// ----------------------------------------------------------------------------
module overspeed_tilt_kill_latch_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ovtk_in_if.sink     in_ch,
  ovtk_out_if.source  out_ch,
  ovtk_cfg_if.sink    cfg_ch
);
  import ovtk_pkg::*;

  localparam logic [3:0] STP_LAST = 4'd12;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic                    use_mag_r;
  logic [LIM_W-1:0]        rate_lim_r;
  logic [DEB_W-1:0]        rate_deb_r;
  logic signed [15:0]      tilt_cos_r;
  logic [DEB_W-1:0]        tilt_deb_r;

  // Sequencer and captured sample.
  logic                    busy_r;
  logic [3:0]              stp_r;
  logic signed [RATE_W-1:0] gx_r, gy_r, gz_r;
  logic signed [QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic [STOP_W-1:0]       stop_r;
  logic                    ack_r, btn_r;

  // Shared multiplier and accumulators.
  logic signed [17:0]      mul_a, mul_b;
  logic signed [35:0]      prod_r;
  logic [31:0]             rsq_r;
  logic [29:0]             lim2_r;
  logic [32:0]             n2_r;
  logic signed [32:0]      num_r;
  logic signed [49:0]      tacc_r;

  // Persistent state.
  logic                    latched_r;
  logic [SRC_W-1:0]        source_r;
  logic [COUNT_BITS-1:0]   rate_cnt_r, tilt_cnt_r;
  logic                    ack_prev_r, btn_prev_r;

  // Output register.
  logic                    out_valid_r;
  logic                    kill_r;
  logic [SRC_W-1:0]        fsrc_r;
  logic [DEB_W-1:0]        rcnt_out_r;
  logic                    over_out_r, ack_out_r;

  // Decision logic.
  logic [16:0]             ax, ay, az;
  logic                    over, tilt, hard, btn_up, ack_up;
  logic                    over_hit, tilt_hit, release_now;
  logic [COUNT_BITS-1:0]   rate_cnt_nxt, tilt_cnt_nxt;
  logic                    latched_nxt;
  logic [SRC_W-1:0]        source_nxt;
  logic signed [49:0]      tilt_lhs;
  logic                    finish;

  assign in_ch.ready  = !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign finish       = busy_r && (stp_r == STP_LAST) && (!out_valid_r || out_ch.ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (stp_r)
      4'd0: begin
        mul_a = 18'(gx_r);
        mul_b = 18'(gx_r);
      end
      4'd1: begin
        mul_a = 18'(gy_r);
        mul_b = 18'(gy_r);
      end
      4'd2: begin
        mul_a = 18'(gz_r);
        mul_b = 18'(gz_r);
      end
      4'd3: begin
        mul_a = {3'b000, rate_lim_r};
        mul_b = {3'b000, rate_lim_r};
      end
      4'd4: begin
        mul_a = 18'(qw_r);
        mul_b = 18'(qw_r);
      end
      4'd5: begin
        mul_a = 18'(qx_r);
        mul_b = 18'(qx_r);
      end
      4'd6: begin
        mul_a = 18'(qy_r);
        mul_b = 18'(qy_r);
      end
      4'd7: begin
        mul_a = 18'(qz_r);
        mul_b = 18'(qz_r);
      end
      4'd9: begin
        mul_a = 18'(tilt_cos_r);
        mul_b = {1'b0, n2_r[16:0]};
      end
      4'd10: begin
        mul_a = 18'(tilt_cos_r);
        mul_b = {2'b00, n2_r[32:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ax = gx_r[15] ? (17'd0 - {1'b1, gx_r}) : {1'b0, gx_r};
    ay = gy_r[15] ? (17'd0 - {1'b1, gy_r}) : {1'b0, gy_r};
    az = gz_r[15] ? (17'd0 - {1'b1, gz_r}) : {1'b0, gz_r};
    if (use_mag_r) begin
      over = rsq_r > {2'b00, lim2_r};
    end else begin
      over = (ax > {2'b00, rate_lim_r}) || (ay > {2'b00, rate_lim_r}) ||
             (az > {2'b00, rate_lim_r});
    end
    tilt_lhs = {{3{num_r[32]}}, num_r, 14'b0};
    tilt     = (n2_r != '0) && (tilt_lhs < tacc_r);
    hard     = stop_r == STOP_HARD;
    btn_up   = btn_r && !btn_prev_r;
    ack_up   = ack_r && !ack_prev_r;

    if (!over) begin
      rate_cnt_nxt = '0;
    end else if ((DEB_W'(rate_cnt_r) < rate_deb_r) && (rate_cnt_r != CNT_MAX)) begin
      rate_cnt_nxt = rate_cnt_r + 1'b1;
    end else begin
      rate_cnt_nxt = rate_cnt_r;
    end
    if (!tilt) begin
      tilt_cnt_nxt = '0;
    end else if ((DEB_W'(tilt_cnt_r) < tilt_deb_r) && (tilt_cnt_r != CNT_MAX)) begin
      tilt_cnt_nxt = tilt_cnt_r + 1'b1;
    end else begin
      tilt_cnt_nxt = tilt_cnt_r;
    end
    over_hit = DEB_W'(rate_cnt_nxt) >= rate_deb_r;
    tilt_hit = DEB_W'(tilt_cnt_nxt) >= tilt_deb_r;

    latched_nxt = latched_r;
    source_nxt  = source_r;
    if (!latched_r) begin
      if (over_hit) begin
        latched_nxt = 1'b1;
        source_nxt  = SRC_RATE;
      end else if (hard) begin
        latched_nxt = 1'b1;
        source_nxt  = SRC_ESTOP;
      end else if (tilt_hit) begin
        latched_nxt = 1'b1;
        source_nxt  = SRC_TILT;
      end else if (btn_up) begin
        latched_nxt = 1'b1;
        source_nxt  = SRC_BUTTON;
      end
    end
    release_now = latched_nxt && ack_up && !over && !tilt && !hard && !btn_r;
    if (release_now) begin
      latched_nxt  = 1'b0;
      source_nxt   = SRC_NONE;
      rate_cnt_nxt = '0;
      tilt_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mag_r  <= 1'b1;
      rate_lim_r <= 15'd20480;
      rate_deb_r <= 16'd5;
      tilt_cos_r <= '0;
      tilt_deb_r <= 16'd10;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_USE_MAG:  use_mag_r  <= cfg_ch.data[0];
        REG_RATE_LIM: rate_lim_r <= cfg_ch.data[LIM_W-1:0];
        REG_RATE_DEB: rate_deb_r <= cfg_ch.data;
        REG_TILT_COS: tilt_cos_r <= cfg_ch.data;
        REG_TILT_DEB: tilt_deb_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      stp_r       <= '0;
      latched_r   <= 1'b0;
      source_r    <= SRC_NONE;
      rate_cnt_r  <= '0;
      tilt_cnt_r  <= '0;
      ack_prev_r  <= 1'b0;
      btn_prev_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && !finish) begin
        out_valid_r <= 1'b0;
      end
      if (in_ch.valid && !busy_r) begin
        busy_r <= 1'b1;
        stp_r  <= '0;
      end else if (finish) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        latched_r   <= latched_nxt;
        source_r    <= source_nxt;
        rate_cnt_r  <= rate_cnt_nxt;
        tilt_cnt_r  <= tilt_cnt_nxt;
        ack_prev_r  <= ack_r;
        btn_prev_r  <= btn_r;
      end else if (busy_r && (stp_r != STP_LAST)) begin
        stp_r <= stp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && !busy_r) begin
      gx_r   <= in_ch.rate_x;
      gy_r   <= in_ch.rate_y;
      gz_r   <= in_ch.rate_z;
      qw_r   <= in_ch.att_w;
      qx_r   <= in_ch.att_x;
      qy_r   <= in_ch.att_y;
      qz_r   <= in_ch.att_z;
      stop_r <= in_ch.stop_level;
      ack_r  <= in_ch.ack_level;
      btn_r  <= in_ch.button_level;
      rsq_r  <= '0;
      n2_r   <= '0;
      num_r  <= '0;
    end
    prod_r <= mul_a * mul_b;
    if (busy_r) begin
      case (stp_r)
        4'd1, 4'd2, 4'd3: rsq_r <= rsq_r + prod_r[31:0];
        4'd4: lim2_r <= prod_r[29:0];
        4'd5, 4'd8: begin
          n2_r  <= n2_r + {1'b0, prod_r[31:0]};
          num_r <= num_r + prod_r[32:0];
        end
        4'd6, 4'd7: begin
          n2_r  <= n2_r + {1'b0, prod_r[31:0]};
          num_r <= num_r - prod_r[32:0];
        end
        4'd10: tacc_r <= 50'(prod_r);
        4'd11: tacc_r <= tacc_r + {prod_r[32:0], 17'b0};
        default: begin
        end
      endcase
    end
    if (finish) begin
      kill_r     <= latched_nxt;
      fsrc_r     <= source_nxt;
      rcnt_out_r <= DEB_W'(rate_cnt_nxt);
      over_out_r <= over;
      ack_out_r  <= ack_up;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kill           = kill_r;
  assign out_ch.fault_source   = fsrc_r;
  assign out_ch.rate_count_out = rcnt_out_r;
  assign out_ch.over_now       = over_out_r;
  assign out_ch.ack_rise       = ack_out_r;

  // The latch and its source code always agree.
  a_latch_src: assert property (@(posedge clk) disable iff (!rst_n)
    latched_r == (source_r != SRC_NONE))
    else $error("latch state and fault source disagree");

  // A held latch keeps its source from one step to the next.
  a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (latched_r && $past(latched_r)) |-> $stable(source_r))
    else $error("fault source changed while latched");

  // A zero quaternion norm can only come with a zero tilt numerator.
  a_norm_num: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && stp_r == STP_LAST && n2_r == '0) |-> (num_r == '0))
    else $error("tilt numerator nonzero with zero norm");

  // A result word only appears at the end of a sample's work.
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(busy_r) && !busy_r))
    else $error("result word without finished sample");

endmodule
